// File: sv/mng_pkg.sv
package mng_pkg;

    // Default sizes of the matrix store
    localparam int MNG_MAX_ROWS     = 64;
    localparam int MNG_MAX_COLS     = 64;
    localparam int MNG_ELEMENT_BITS = 32;

    // Configuration port
    localparam int CFG_DATA_BITS  = 7;
    localparam int CFG_INDEX_BITS = 1;
    localparam int DIM_RESET      = 64;

    localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_ROWS = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_COLS = 1'd1;

    // Input command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_GIVEN = 2'd0;
    localparam logic [1:0] STATUS_NONE  = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic write_elem;
        logic load_query;
        logic emit_bad;
        logic emit_none;
        logic scan_step;
    } mng_ctrl_t;

    // Status from datapath to controller
    typedef struct packed {
        logic pos_bad;
        logic no_nbr;
        logic scan_done;
    } mng_stat_t;

endpackage

// File: sv/matrix_neighbour_gather_core.sv
// Channel  Direction  Transfer when        Signals
// -------  ---------  -------------------  ---------------------------------------------
// item     in         start && !busy       command, row, col, value
// result   out        strobe (one cycle)   status, neighbour_row, neighbour_col,
//                                          neighbour_value, last
// config   in         cfg_write            cfg_index, cfg_data
//
// A write is stored when it is taken and leaves busy low. A query inside the matrix holds
// busy while it steps through the eight offsets, one at a time, via the single read port
// of the matrix store; its results are registered, in row-major order. A query outside the matrix
// or with no neighbours gives its one result the next cycle and busy stays low.
// Reset sets num_rows and num_cols to 64; the store is not cleared.
// Results cannot be held off: each one stands for exactly one cycle.
module matrix_neighbour_gather_core
    import mng_pkg::*;
#(
    parameter int MAX_ROWS     = MNG_MAX_ROWS,
    parameter int MAX_COLS     = MNG_MAX_COLS,
    parameter int ELEMENT_BITS = MNG_ELEMENT_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      command,
    input  logic [5:0]                row,
    input  logic [5:0]                col,
    input  logic signed [31:0]        value,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output logic                      strobe,
    output logic [1:0]                status,
    output logic [5:0]                neighbour_row,
    output logic [5:0]                neighbour_col,
    output logic signed [31:0]        neighbour_value,
    output logic                      last
);

    mng_ctrl_t ctrl;
    mng_stat_t stat;

    // Sequence items and scans
    mng_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .busy    (busy),
        .ctrl    (ctrl)
    );

    // Store, neighbour scan and result registers
    mng_datapath #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COLS     (MAX_COLS),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .stat            (stat),
        .row             (row),
        .col             (col),
        .value           (value),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .strobe          (strobe),
        .status          (status),
        .neighbour_row   (neighbour_row),
        .neighbour_col   (neighbour_col),
        .neighbour_value (neighbour_value),
        .last            (last)
    );

endmodule

// File: sv/mng_ctrl.sv
module mng_ctrl
    import mng_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      command,
    input  mng_stat_t stat,
    output logic      busy,
    output mng_ctrl_t ctrl
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   accept;
    logic   is_query;

    assign busy     = busy_reg;
    assign accept   = start && !busy_reg;
    assign is_query = (command == CMD_QUERY);

    // Decode commands for the datapath
    always_comb
    begin
        ctrl.write_elem = accept && (command == CMD_WRITE);
        ctrl.load_query = accept && is_query && !stat.pos_bad && !stat.no_nbr;
        ctrl.emit_bad   = accept && is_query && stat.pos_bad;
        ctrl.emit_none  = accept && is_query && !stat.pos_bad && stat.no_nbr;
        ctrl.scan_step  = (state_reg == ST_SCAN);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.load_query)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next == ST_SCAN);
        end
    end

    // Only one result source may fire in a cycle
    a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.emit_bad, ctrl.emit_none, ctrl.scan_step}))
        else $error("more than one result source active");

    // No store write while a scan is running
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !ctrl.write_elem && !ctrl.load_query)
        else $error("item taken while busy");

endmodule

// File: sv/mng_datapath.sv
module mng_datapath
    import mng_pkg::*;
#(
    parameter int MAX_ROWS     = MNG_MAX_ROWS,
    parameter int MAX_COLS     = MNG_MAX_COLS,
    parameter int ELEMENT_BITS = MNG_ELEMENT_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  mng_ctrl_t                 ctrl,
    output mng_stat_t                 stat,
    input  logic [5:0]                row,
    input  logic [5:0]                col,
    input  logic signed [31:0]        value,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output logic                      strobe,
    output logic [1:0]                status,
    output logic [5:0]                neighbour_row,
    output logic [5:0]                neighbour_col,
    output logic signed [31:0]        neighbour_value,
    output logic                      last
);

    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int DIM_MAX     = (1 << CFG_DATA_BITS) - 1;
    localparam int ROW_CAP     = (MAX_ROWS > DIM_MAX) ? DIM_MAX : MAX_ROWS;
    localparam int COL_CAP     = (MAX_COLS > DIM_MAX) ? DIM_MAX : MAX_COLS;

    logic [CFG_DATA_BITS-1:0] num_rows_reg;
    logic [CFG_DATA_BITS-1:0] num_cols_reg;
    logic [CFG_DATA_BITS-1:0] nr_eff;
    logic [CFG_DATA_BITS-1:0] nc_eff;

    logic [5:0] qrow_reg;
    logic [5:0] qcol_reg;
    logic [7:0] mask_reg;
    logic [7:0] mask_next;
    logic [2:0] k_reg;

    logic signed [ELEMENT_BITS-1:0] mem [STORE_DEPTH];
    logic signed [ELEMENT_BITS-1:0] rd_data_reg;

    logic [ADDR_BITS-1:0] wr_addr;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 wr_in_range;
    logic                 up_ok;
    logic                 dn_ok;
    logic                 lf_ok;
    logic                 rt_ok;
    logic [5:0]           tap_row;
    logic [5:0]           tap_col;
    logic                 hit;
    logic                 later_none;

    logic       strobe_reg;
    logic       strobe_next;
    logic [1:0] status_reg;
    logic [1:0] status_next;
    logic [5:0] nrow_reg;
    logic [5:0] nrow_next;
    logic [5:0] ncol_reg;
    logic [5:0] ncol_next;
    logic       last_reg;
    logic       last_next;
    logic       from_mem_reg;

    // Clip the configured size to the store size
    assign nr_eff = (num_rows_reg > CFG_DATA_BITS'(ROW_CAP)) ?
                    CFG_DATA_BITS'(ROW_CAP) : num_rows_reg;
    assign nc_eff = (num_cols_reg > CFG_DATA_BITS'(COL_CAP)) ?
                    CFG_DATA_BITS'(COL_CAP) : num_cols_reg;

    // Classify the query position and build the neighbour mask
    always_comb
    begin
        stat.pos_bad = ({1'b0, row} >= nr_eff) || ({1'b0, col} >= nc_eff);
        up_ok        = (row != 6'd0);
        lf_ok        = (col != 6'd0);
        dn_ok        = (({1'b0, row} + 7'd1) < nr_eff);
        rt_ok        = (({1'b0, col} + 7'd1) < nc_eff);
        mask_next    = {dn_ok && rt_ok, dn_ok, dn_ok && lf_ok, rt_ok, lf_ok,
                        up_ok && rt_ok, up_ok, up_ok && lf_ok};
        stat.no_nbr  = (mask_next == 8'd0);
        stat.scan_done = (k_reg == 3'd7);
    end

    // Offset position of the current scan step, row-major order
    always_comb
    begin
        case (k_reg)
            3'd0:    begin tap_row = qrow_reg - 6'd1; tap_col = qcol_reg - 6'd1; end
            3'd1:    begin tap_row = qrow_reg - 6'd1; tap_col = qcol_reg;        end
            3'd2:    begin tap_row = qrow_reg - 6'd1; tap_col = qcol_reg + 6'd1; end
            3'd3:    begin tap_row = qrow_reg;        tap_col = qcol_reg - 6'd1; end
            3'd4:    begin tap_row = qrow_reg;        tap_col = qcol_reg + 6'd1; end
            3'd5:    begin tap_row = qrow_reg + 6'd1; tap_col = qcol_reg - 6'd1; end
            3'd6:    begin tap_row = qrow_reg + 6'd1; tap_col = qcol_reg;        end
            default: begin tap_row = qrow_reg + 6'd1; tap_col = qcol_reg + 6'd1; end
        endcase
    end

    // Store addresses
    assign wr_in_range = (32'(row) < 32'(MAX_ROWS)) && (32'(col) < 32'(MAX_COLS));
    assign wr_addr = ADDR_BITS'(row) * ADDR_BITS'(MAX_COLS) + ADDR_BITS'(col);
    assign rd_addr = ADDR_BITS'(tap_row) * ADDR_BITS'(MAX_COLS) + ADDR_BITS'(tap_col);

    assign hit        = ctrl.scan_step && mask_reg[k_reg];
    assign later_none = (((mask_reg >> k_reg) >> 1) == 8'd0);

    // Write and read the matrix store
    always_ff @(posedge clk)
    begin
        if (ctrl.write_elem && wr_in_range)
        begin
            mem[wr_addr] <= ELEMENT_BITS'($unsigned(value));
        end
        if (hit)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Build the next result
    always_comb
    begin
        strobe_next = ctrl.emit_bad || ctrl.emit_none || hit;
        if (ctrl.emit_bad)
        begin
            status_next = STATUS_BAD;
        end
        else if (ctrl.emit_none)
        begin
            status_next = STATUS_NONE;
        end
        else
        begin
            status_next = STATUS_GIVEN;
        end
        nrow_next = hit ? tap_row : 6'd0;
        ncol_next = hit ? tap_col : 6'd0;
        last_next = hit ? later_none : 1'b1;
    end

    // Hold configuration, scan control and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= CFG_DATA_BITS'(DIM_RESET);
            num_cols_reg <= CFG_DATA_BITS'(DIM_RESET);
            k_reg        <= 3'd0;
            mask_reg     <= 8'd0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index == REG_NUM_ROWS))
            begin
                num_rows_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == REG_NUM_COLS))
            begin
                num_cols_reg <= cfg_data;
            end
            if (ctrl.load_query)
            begin
                k_reg    <= 3'd0;
                mask_reg <= mask_next;
            end
            else if (ctrl.scan_step)
            begin
                k_reg <= k_reg + 3'd1;
            end
            strobe_reg <= strobe_next;
        end
    end

    // Capture query position and result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.load_query)
        begin
            qrow_reg <= row;
            qcol_reg <= col;
        end
        if (strobe_next)
        begin
            status_reg   <= status_next;
            nrow_reg     <= nrow_next;
            ncol_reg     <= ncol_next;
            last_reg     <= last_next;
            from_mem_reg <= hit;
        end
    end

    assign strobe          = strobe_reg;
    assign status          = status_reg;
    assign neighbour_row   = nrow_reg;
    assign neighbour_col   = ncol_reg;
    assign last            = last_reg;
    assign neighbour_value = from_mem_reg ? 32'(rd_data_reg) : 32'sd0;

    // A status-only result is always the final one
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && (status_reg != STATUS_GIVEN) |-> last_reg)
        else $error("status result not marked last");

    // A scan starts from the first offset with a non-empty neighbour mask
    a_load_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_query |=> (k_reg == 3'd0) && (mask_reg != 8'd0))
        else $error("scan loaded with empty mask");

    // A read at the last valid offset yields the last result next cycle
    a_last_hit: assert property (@(posedge clk) disable iff (!rst_n)
        hit && later_none |=> strobe_reg && last_reg && (status_reg == STATUS_GIVEN))
        else $error("final neighbour not marked last");

endmodule

// File: tb/tb_matrix_neighbour_gather_core.sv
`timescale 1ns / 1ps

module tb_matrix_neighbour_gather_core;
    import mng_pkg::*;

    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 12;
    localparam int ITEM_TARGET   = 350;

    typedef struct packed {
        logic               command;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] value;
    } matrix_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         nb_row;
        logic [5:0]         nb_col;
        logic signed [31:0] nb_value;
        logic               last;
    } nbr_result_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      start     = 1'b0;
    logic                      command   = CMD_WRITE;
    logic [5:0]                row       = '0;
    logic [5:0]                col       = '0;
    logic signed [31:0]        value     = '0;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_NUM_ROWS;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                      busy;
    logic                      strobe;
    logic [1:0]                status;
    logic [5:0]                neighbour_row;
    logic [5:0]                neighbour_col;
    logic signed [31:0]        neighbour_value;
    logic                      last;

    matrix_item_t       pending_items[$];
    nbr_result_t        nbr_expected[$];
    matrix_item_t       cur_item;
    logic signed [31:0] shadow_store [0:4095];
    bit                 filled_cells [0:4095];
    logic [CFG_DATA_BITS-1:0] rows_reg = CFG_DATA_BITS'(DIM_RESET);
    logic [CFG_DATA_BITS-1:0] cols_reg = CFG_DATA_BITS'(DIM_RESET);

    int gap_left       = 0;
    bit steady         = 1'b0;
    int items_made     = 0;
    int items_sent     = 0;
    int query_count    = 0;
    int results_checked = 0;
    int given_count    = 0;
    int none_count     = 0;
    int bad_count      = 0;
    int dim_settings   = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;

    matrix_neighbour_gather_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .row             (row),
        .col             (col),
        .value           (value),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .strobe          (strobe),
        .status          (status),
        .neighbour_row   (neighbour_row),
        .neighbour_col   (neighbour_col),
        .neighbour_value (neighbour_value),
        .last            (last)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Clamp a dimension register to the store size
    function automatic int dim_limit(input logic [6:0] dim_val, input int max_dim);
        return (dim_val > max_dim) ? max_dim : int'(dim_val);
    endfunction

    // Append one result to the expected stream
    function automatic void add_expected(input nbr_result_t res);
        nbr_expected = {nbr_expected, res};
    endfunction

    // Mostly random elements, with the extremes mixed in
    function automatic logic signed [31:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0000_0000;
            3: return 32'shffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Mostly short sender gaps, a few long ones, none in steady stretches
    function automatic int draw_gap();
        int pick;
        if (steady)
        begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            return 0;
        end
        else if (pick < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (pick < 95)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // Apply one accepted item: store a write, or gather the expected neighbours
    task automatic gather_neighbours(input matrix_item_t it);
        int lim_r;
        int lim_c;
        int tr;
        int tc;
        nbr_result_t found[$];
        nbr_result_t res;
        if (it.command == CMD_WRITE)
        begin
            shadow_store[{it.row, it.col}] = it.value;
            return;
        end
        query_count++;
        lim_r = dim_limit(rows_reg, MNG_MAX_ROWS);
        lim_c = dim_limit(cols_reg, MNG_MAX_COLS);
        if (int'(it.row) >= lim_r || int'(it.col) >= lim_c)
        begin
            res = '{STATUS_BAD, 6'd0, 6'd0, 32'sd0, 1'b1};
            add_expected(res);
            return;
        end
        // Scan the offsets in row-major order, skip the center and the outside
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                tr = int'(it.row) + dr;
                tc = int'(it.col) + dc;
                if (!(dr == 0 && dc == 0) && tr >= 0 && tc >= 0 && tr < lim_r && tc < lim_c)
                begin
                    res.status   = STATUS_GIVEN;
                    res.nb_row   = tr[5:0];
                    res.nb_col   = tc[5:0];
                    res.nb_value = shadow_store[{tr[5:0], tc[5:0]}];
                    res.last     = 1'b0;
                    found = {found, res};
                end
            end
        end
        if (found.size() == 0)
        begin
            res = '{STATUS_NONE, 6'd0, 6'd0, 32'sd0, 1'b1};
            add_expected(res);
            return;
        end
        found[found.size() - 1].last = 1'b1;
        foreach (found[i])
        begin
            add_expected(found[i]);
        end
    endtask

    task automatic queue_item(input logic cmd, input logic [5:0] r, input logic [5:0] c,
                              input logic signed [31:0] v);
        matrix_item_t it;
        it = '{cmd, r, c, v};
        pending_items = {pending_items, it};
        items_made++;
        if (cmd == CMD_WRITE)
        begin
            filled_cells[{r, c}] = 1'b1;
        end
    endtask

    // Write every neighbour not yet stored, then ask for the neighbourhood
    task automatic queue_query(input logic [5:0] r, input logic [5:0] c);
        int tr;
        int tc;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                tr = int'(r) + dr;
                tc = int'(c) + dc;
                if (!(dr == 0 && dc == 0) && tr >= 0 && tc >= 0 && tr < 64 && tc < 64)
                begin
                    if (!filled_cells[{tr[5:0], tc[5:0]}])
                    begin
                        queue_item(CMD_WRITE, tr[5:0], tc[5:0], rand_elem());
                    end
                end
            end
        end
        queue_item(CMD_QUERY, r, c, $urandom);
    endtask

    // Hold until every item and result is through, then let the block settle
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_items.size() != 0 || nbr_expected.size() != 0 || start || busy);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_dims(input logic [6:0] nrows, input logic [6:0] ncols);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_NUM_ROWS;
        cfg_data  <= nrows;
        @(posedge clk);
        rows_reg = nrows;
        cfg_index <= REG_NUM_COLS;
        cfg_data  <= ncols;
        @(posedge clk);
        cols_reg = ncols;
        cfg_write <= 1'b0;
        @(negedge clk);
        dim_settings++;
    endtask

    // Mix of well-formed queries, stray writes and queries anywhere
    task automatic random_phase(input int count);
        int lim_r;
        int lim_c;
        int kind;
        lim_r = dim_limit(rows_reg, MNG_MAX_ROWS);
        lim_c = dim_limit(cols_reg, MNG_MAX_COLS);
        repeat (count)
        begin
            if (items_made >= ITEM_TARGET)
            begin
                break;
            end
            kind = $urandom_range(0, 99);
            if (kind < 65 && lim_r > 0 && lim_c > 0)
            begin
                queue_query(6'($urandom_range(0, lim_r - 1)),
                            6'($urandom_range(0, lim_c - 1)));
            end
            else if (kind < 85)
            begin
                queue_item(CMD_WRITE, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                           rand_elem());
            end
            else
            begin
                queue_query(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
            end
        end
    endtask

    // Present items; predict each one at its transfer
    always @(posedge clk)
    begin : item_driver
        matrix_item_t next_item;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                gather_neighbours(cur_item);
                items_sent++;
                gap_left = draw_gap();
            end
            if (!start || !busy)
            begin
                if (gap_left == 0 && pending_items.size() != 0)
                begin
                    next_item = pending_items.pop_front();
                    cur_item  = next_item;
                    start   <= 1'b1;
                    command <= next_item.command;
                    row     <= next_item.row;
                    col     <= next_item.col;
                    value   <= next_item.value;
                end
                else
                begin
                    start <= 1'b0;
                    if (gap_left > 0)
                    begin
                        gap_left--;
                    end
                end
            end
        end
    end

    // Check each strobed result against the oldest expectation
    always @(posedge clk)
    begin : result_monitor
        nbr_result_t got;
        nbr_result_t want;
        if (rst_n && strobe)
        begin
            got = '{status, neighbour_row, neighbour_col, neighbour_value, last};
            if (nbr_expected.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result: status %0d row %0d col %0d value %0d last %0d",
                         $time, got.status, got.nb_row, got.nb_col, got.nb_value, got.last);
            end
            else
            begin
                want = nbr_expected.pop_front();
                results_checked++;
                case (want.status)
                    STATUS_GIVEN: given_count++;
                    STATUS_NONE:  none_count++;
                    default:      bad_count++;
                endcase
                if (got.status !== want.status || got.nb_row !== want.nb_row ||
                    got.nb_col !== want.nb_col || got.nb_value !== want.nb_value ||
                    got.last !== want.last)
                begin
                    fail_count++;
                    $display("%0t: expected status %0d row %0d col %0d value %0d last %0d",
                             $time, want.status, want.nb_row, want.nb_col, want.nb_value,
                             want.last);
                    $display("%0t: actual   status %0d row %0d col %0d value %0d last %0d",
                             $time, got.status, got.nb_row, got.nb_col, got.nb_value,
                             got.last);
                end
            end
        end
    end

    // Drop the run if nothing transfers for too long
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (start && !busy) || strobe || cfg_write)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("matrix_neighbour_gather_core: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase;
        phase = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Corner queries with extreme elements and an interior point
        queue_item(CMD_WRITE, 6'd0, 6'd0, 32'sh0000_0000);
        queue_item(CMD_WRITE, 6'd0, 6'd1, 32'sh7fff_ffff);
        queue_item(CMD_WRITE, 6'd1, 6'd0, 32'sh8000_0000);
        queue_item(CMD_WRITE, 6'd1, 6'd1, 32'shffff_ffff);
        queue_query(6'd0, 6'd0);
        queue_item(CMD_WRITE, 6'd63, 6'd62, 32'sh8000_0000);
        queue_item(CMD_WRITE, 6'd62, 6'd63, 32'sh7fff_ffff);
        queue_item(CMD_WRITE, 6'd62, 6'd62, 32'sh0000_0001);
        queue_query(6'd63, 6'd63);
        queue_query(6'd0, 6'd63);
        queue_query(6'd31, 6'd40);
        wait_drained();

        // Single element: no neighbours; anything else lies outside
        set_dims(7'd1, 7'd1);
        queue_query(6'd0, 6'd0);
        queue_query(6'd0, 6'd1);
        queue_query(6'd63, 6'd0);
        wait_drained();

        // Empty matrix
        set_dims(7'd0, 7'd64);
        queue_query(6'd0, 6'd0);
        wait_drained();

        // Oversized registers saturate to the store size
        set_dims(7'd127, 7'd100);
        queue_query(6'd63, 6'd63);
        wait_drained();

        // Random phases, each under its own matrix size
        while (items_made < ITEM_TARGET)
        begin
            case (phase % 8)
                0: set_dims(7'd64, 7'd64);
                1: set_dims(7'd1, 7'd64);
                2: set_dims(7'd64, 7'd1);
                3: set_dims(7'd2, 7'd2);
                4: set_dims(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)));
                5: set_dims(7'd3, 7'd5);
                6: set_dims(7'd127, 7'd127);
                default: set_dims(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            endcase
            steady = ($urandom_range(0, 3) == 0);
            random_phase(6);
            wait_drained();
            phase++;
        end

        $display("Transferred %0d items (%0d queries) over %0d matrix sizes.",
                 items_sent, query_count, dim_settings);
        $display("Checked %0d results: %0d neighbours, %0d empty, %0d outside.",
                 results_checked, given_count, none_count, bad_count);
        if (fail_count == 0 && nbr_expected.size() == 0)
        begin
            $display("matrix_neighbour_gather_core: match");
        end
        else
        begin
            $display("matrix_neighbour_gather_core: mismatch");
        end
        $finish;
    end

endmodule
